// ===== sv/cteb_pkg.sv =====
// Shared types and constants for the cursor text edit buffer.
`timescale 1ns / 1ps
`default_nettype none

package cteb_pkg;

   localparam int MAX_CHARS_DEFAULT = 1024;
   localparam int LEN_W             = 11;
   localparam int CHAR_W            = 8;
   localparam int IDX_W             = 10;
   localparam int KIND_W            = 3;
   localparam int STATUS_W          = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 3'd0,
      KIND_LEFT   = 3'd1,
      KIND_RIGHT  = 3'd2,
      KIND_BACK   = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_IGNORED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_MEM  = 2'b10
   } state_type;

   typedef struct packed {
      status_type         status;
      logic [CHAR_W-1:0]  char_out;
      logic [LEN_W-1:0]   cursor_pos;
      logic [LEN_W-1:0]   text_length;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/cteb_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module cteb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/cteb_ctrl.sv =====
// Gap buffer sequencer: cursor counters and memory read-modify-write.
`timescale 1ns / 1ps
`default_nettype none

module cteb_ctrl import cteb_pkg::*; #(
   parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [KIND_W-1:0]            req_kind,
   input  wire logic [CHAR_W-1:0]            req_char,
   input  wire logic [IDX_W-1:0]             req_index,
   input  wire logic                         out_free,
   output logic                              res_valid,
   output rsp_type                           res,
   output logic                              mem_wr_en,
   output logic [$clog2(MAX_CHARS)-1:0]      mem_wr_addr,
   output logic [CHAR_W-1:0]                 mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(MAX_CHARS)-1:0]      mem_rd_addr,
   input  wire logic [CHAR_W-1:0]            mem_rd_data
);

   localparam int AW = $clog2(MAX_CHARS);
   localparam int CW = $clog2(MAX_CHARS + 1);
   localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;

   state_type      state_ff, state_in;
   logic [CW-1:0]  before_ff, before_in;
   logic [CW-1:0]  after_ff, after_in;
   kind_type       op_ff, op_in;

   logic [CW-1:0]  len;
   logic [CW-1:0]  before_m1;
   logic [CW-1:0]  upper_base;
   logic [CW-1:0]  upper_m1;
   logic [XW-1:0]  len_x;
   logic [XW-1:0]  idx_x;
   logic [XW-1:0]  upper_idx;
   logic           fire;
   status_type     status_v;
   logic [CHAR_W-1:0] char_v;

   assign len        = before_ff + after_ff;
   assign before_m1  = before_ff - CW'(1);
   assign upper_base = CW'(MAX_CHARS) - after_ff;
   assign upper_m1   = CW'(MAX_CHARS - 1) - after_ff;
   assign len_x      = XW'(len);
   assign idx_x      = XW'(req_index);
   assign upper_idx  = XW'(MAX_CHARS) - len_x + idx_x;

   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign fire      = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      before_in   = before_ff;
      after_in    = after_ff;
      op_in       = op_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = before_ff[AW-1:0];
      mem_wr_data = req_char;
      mem_rd_en   = 1'b0;
      mem_rd_addr = before_m1[AW-1:0];
      res_valid   = 1'b0;
      status_v    = STATUS_DONE;
      char_v      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               res_valid = 1'b1;
               unique case (req_kind)
                  KIND_INSERT: begin
                     if (len == CW'(MAX_CHARS)) begin
                        status_v = STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        before_in = before_ff + CW'(1);
                     end
                  end
                  KIND_LEFT: begin
                     if (before_ff == '0) begin
                        status_v = STATUS_IGNORED;
                     end else begin
                        res_valid   = 1'b0;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = before_m1[AW-1:0];
                        op_in       = KIND_LEFT;
                        state_in    = ST_MEM;
                     end
                  end
                  KIND_RIGHT: begin
                     if (after_ff == '0) begin
                        status_v = STATUS_IGNORED;
                     end else begin
                        res_valid   = 1'b0;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = upper_base[AW-1:0];
                        op_in       = KIND_RIGHT;
                        state_in    = ST_MEM;
                     end
                  end
                  KIND_BACK: begin
                     if (before_ff == '0) begin
                        status_v = STATUS_IGNORED;
                     end else begin
                        before_in = before_m1;
                     end
                  end
                  KIND_READ: begin
                     if (idx_x >= len_x) begin
                        status_v = STATUS_IGNORED;
                     end else begin
                        res_valid = 1'b0;
                        mem_rd_en = 1'b1;
                        if (idx_x < XW'(before_ff)) begin
                           mem_rd_addr = AW'(req_index);
                        end else begin
                           mem_rd_addr = upper_idx[AW-1:0];
                        end
                        op_in    = KIND_READ;
                        state_in = ST_MEM;
                     end
                  end
                  default: begin
                     status_v = STATUS_IGNORED;
                  end
               endcase
            end
         end
         ST_MEM: begin
            state_in  = ST_IDLE;
            res_valid = 1'b1;
            unique case (op_ff)
               KIND_LEFT: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = upper_m1[AW-1:0];
                  mem_wr_data = mem_rd_data;
                  before_in   = before_m1;
                  after_in    = after_ff + CW'(1);
               end
               KIND_RIGHT: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = before_ff[AW-1:0];
                  mem_wr_data = mem_rd_data;
                  before_in   = before_ff + CW'(1);
                  after_in    = after_ff - CW'(1);
               end
               default: begin
                  char_v = mem_rd_data;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      res.text_length = LEN_W'(before_in + after_in);
      res.cursor_pos  = LEN_W'(before_in);
      res.char_out    = char_v;
      res.status      = status_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         before_ff <= '0;
         after_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         before_ff <= before_in;
         after_ff  <= after_in;
      end
      op_ff <= op_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (XW'(before_ff) + XW'(after_ff)) <= XW'(MAX_CHARS))
      else $error("text length exceeds capacity");

   a_mem_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEM) |=> (state_ff == ST_IDLE))
      else $error("memory step did not return to idle");

   a_mem_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEM) |-> (res_valid && !mem_rd_en))
      else $error("memory step without result or with a new read");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> !mem_wr_en)
      else $error("read and write issued in the same cycle");

   a_move_keeps_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEM) |=> (before_ff + after_ff) == $past(before_ff + after_ff))
      else $error("cursor move changed text length");

endmodule

`default_nettype wire

// ===== sv/cursor_text_edit_buffer.sv =====
// Top level of the cursor text edit buffer: gap buffer memory, sequencer, output register.
//
// Usage:
//   Requests enter on req_ (tvalid/tready/tdata/tuser); req_tuser carries the
//   operation kind (insert, left, right, backspace, read). One response per
//   request leaves on rsp_ with the text length, cursor position, read byte
//   and status.
//   Insert, backspace and ignored requests finish in the idle state; left,
//   right and an in-range read also pass through the memory state, set by the
//   single memory: a read in the idle state, the write of the moved byte or the
//   capture of the read byte in the memory state. The response is registered
//   and shows on rsp_ in the cycle after the last cycle of its request.
//   A new request is taken once the previous one has finished and the output
//   register is empty or being drained in the same cycle; while the receiver
//   holds rsp_tready low with a response pending, req_tready stays low.
//   Reset empties the text and places the cursor at zero; memory contents
//   are not cleared, as every entry read was written before.
`timescale 1ns / 1ps
`default_nettype none

module cursor_text_edit_buffer import cteb_pkg::*; #(
   parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // char_in[7:0], read_index[17:8], zero [23:18]
   input  wire logic [2:0]  req_tuser,   // kind[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // text_length[10:0], cursor_pos[21:11],
                                         // char_out[29:22], status[31:30]
);

   localparam int AW = $clog2(MAX_CHARS);

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   logic              out_free;
   logic              res_valid;
   rsp_type           res;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CHAR_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [CHAR_W-1:0] mem_rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;

   cteb_ctrl #(
      .MAX_CHARS (MAX_CHARS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_char    (req_tdata[7:0]),
      .req_index   (req_tdata[17:8]),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   cteb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_CHARS)
   ) u_text_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the cursor text edit buffer: random editing streams with stalls.
`timescale 1ns / 1ps

module tb;
   import cteb_pkg::*;

   localparam int TEXT_CAP   = MAX_CHARS_DEFAULT;
   localparam int CYCLE_CAP  = 400000;
   localparam int HOLD_LONG  = 60;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
      int                gap;
      bit                drain;
   } edit_cmd_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   edit_cmd_type edit_cmd_q[$];
   rsp_type      edit_result_q[$];
   logic [7:0]   line_text[$];
   int           line_cursor;

   edit_cmd_type staged_cmd;
   edit_cmd_type offered_cmd;
   bit          cmd_loaded;
   int          gap_left;
   int          stall_left;
   int          hold_left;

   int          gen_len;
   int          gen_cur;
   int          total_cmds;
   int          sent_count;
   int          rsp_count;
   int          cycle_count;
   int          errors;
   int          n_insert;
   int          n_read;
   int          n_refused;
   int          n_dropped;
   int          peak_len;

   cursor_text_edit_buffer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic void apply_edit(input edit_cmd_type c);
      rsp_type r;
      int len;
      len = line_text.size();
      r.char_out = '0;
      r.status = STATUS_DONE;
      case (c.kind)
         KIND_INSERT: begin
            n_insert++;
            if (len >= TEXT_CAP) begin
               r.status = STATUS_FULL;
               n_dropped++;
            end else begin
               line_text.insert(line_cursor, c.ch);
               line_cursor++;
            end
         end
         KIND_LEFT: begin
            if (line_cursor == 0) r.status = STATUS_IGNORED;
            else line_cursor--;
         end
         KIND_RIGHT: begin
            if (line_cursor == len) r.status = STATUS_IGNORED;
            else line_cursor++;
         end
         KIND_BACK: begin
            if (line_cursor == 0) begin
               r.status = STATUS_IGNORED;
            end else begin
               line_text.delete(line_cursor - 1);
               line_cursor--;
            end
         end
         KIND_READ: begin
            n_read++;
            if (c.idx >= len) r.status = STATUS_IGNORED;
            else r.char_out = line_text[c.idx];
         end
         default: r.status = STATUS_IGNORED;
      endcase
      if (r.status == STATUS_IGNORED) n_refused++;
      if (line_text.size() > peak_len) peak_len = line_text.size();
      r.text_length = LEN_W'(line_text.size());
      r.cursor_pos  = LEN_W'(line_cursor);
      edit_result_q.insert(edit_result_q.size(), r);
   endfunction

   function automatic void queue_cmd(input logic [2:0] k, input logic [7:0] ch,
                                     input logic [9:0] ix, input bit drain);
      edit_cmd_type c;
      c.kind  = k;
      c.ch    = ch;
      c.idx   = ix;
      c.drain = drain;
      c.gap   = ((edit_cmd_q.size() / 100) % 4 == 1) ? 0 : $urandom_range(0, 4);
      edit_cmd_q.insert(edit_cmd_q.size(), c);
      case (k)
         KIND_INSERT: if (gen_len < TEXT_CAP) begin
            gen_len++;
            gen_cur++;
         end
         KIND_LEFT:  if (gen_cur > 0) gen_cur--;
         KIND_RIGHT: if (gen_cur < gen_len) gen_cur++;
         KIND_BACK:  if (gen_cur > 0) begin
            gen_cur--;
            gen_len--;
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_random(input int w_ins, input int w_move, input int w_back,
                                        input int w_read, input int w_odd, input bit drain);
      int roll;
      logic [2:0] k;
      logic [9:0] ix;
      roll = $urandom_range(0, w_ins + w_move + w_back + w_read + w_odd - 1);
      ix = 10'($urandom_range(0, 1023));
      if (roll < w_ins) begin
         k = KIND_INSERT;
      end else if (roll < w_ins + w_move) begin
         k = ($urandom_range(0, 1) != 0) ? KIND_LEFT : KIND_RIGHT;
      end else if (roll < w_ins + w_move + w_back) begin
         k = KIND_BACK;
      end else if (roll < w_ins + w_move + w_back + w_read) begin
         k = KIND_READ;
         if (gen_len > 0 && $urandom_range(0, 3) != 0) ix = 10'($urandom_range(0, gen_len - 1));
      end else begin
         k = 3'(KIND_READ) + 3'($urandom_range(1, 3));
      end
      queue_cmd(k, 8'($urandom_range(0, 255)), ix, drain);
   endfunction

   // request driver
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_edit(offered_cmd);
            sent_count++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (!cmd_loaded && edit_cmd_q.size() > 0) begin
               staged_cmd = edit_cmd_q.pop_front();
               gap_left   = staged_cmd.gap;
               cmd_loaded = 1'b1;
            end
            if (cmd_loaded && !(staged_cmd.drain && edit_result_q.size() > 0)) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  offered_cmd = staged_cmd;
                  cmd_loaded  = 1'b0;
                  offer       = 1'b1;
                  req_tdata  <= {6'd0, staged_cmd.idx, staged_cmd.ch};
                  req_tuser  <= staged_cmd.kind;
               end
            end
         end
         req_tvalid <= offer;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            rsp_count++;
            if (edit_result_q.size() == 0) begin
               $display("%0t: response with none pending, expected nothing, actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = edit_result_q.pop_front();
               if (got.text_length !== want.text_length) begin
                  $display("%0t: text_length expected %0d actual %0d",
                           $time, want.text_length, got.text_length);
                  errors++;
               end
               if (got.cursor_pos !== want.cursor_pos) begin
                  $display("%0t: cursor_pos expected %0d actual %0d",
                           $time, want.cursor_pos, got.cursor_pos);
                  errors++;
               end
               if (got.char_out !== want.char_out) begin
                  $display("%0t: char_out expected %h actual %h",
                           $time, want.char_out, got.char_out);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  errors++;
               end
            end
            stall_left = ((rsp_count / 100) % 4 == 2) ? 0 : $urandom_range(0, 4);
            if (rsp_count == 300 || rsp_count == 900) hold_left = HOLD_LONG;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_CAP) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int i;
      queue_cmd(KIND_LEFT,   8'h00, 10'd0,    1'b0);
      queue_cmd(KIND_RIGHT,  8'h00, 10'd0,    1'b0);
      queue_cmd(KIND_BACK,   8'h00, 10'd0,    1'b0);
      queue_cmd(KIND_READ,   8'h00, 10'd0,    1'b0);
      queue_cmd(KIND_READ,   8'h00, 10'h3FF,  1'b0);
      queue_cmd(KIND_INSERT, 8'h00, 10'd0,    1'b0);
      queue_cmd(KIND_INSERT, 8'hFF, 10'h3FF,  1'b0);
      queue_cmd(KIND_INSERT, 8'hA5, 10'd0,    1'b0);
      queue_cmd(KIND_INSERT, 8'h5A, 10'd0,    1'b0);
      for (i = 0; i < 4; i++) queue_cmd(KIND_READ, 8'h00, 10'(i), 1'b0);
      queue_cmd(KIND_LEFT,   8'h00, 10'd0,    1'b0);
      queue_cmd(KIND_LEFT,   8'h00, 10'd0,    1'b0);
      queue_cmd(KIND_READ,   8'h00, 10'd2,    1'b0);
      queue_cmd(KIND_READ,   8'h00, 10'd3,    1'b0);
      queue_cmd(KIND_INSERT, 8'h3C, 10'd0,    1'b0);
      queue_cmd(KIND_BACK,   8'h00, 10'd0,    1'b0);
      for (i = 0; i < 3; i++) queue_cmd(KIND_RIGHT, 8'h00, 10'd0, 1'b0);
      queue_cmd(KIND_READ,   8'h00, 10'h2AA,  1'b0);
      queue_cmd(3'(KIND_READ) + 3'd1, 8'hC3, 10'h155, 1'b0);
      queue_cmd(3'(KIND_READ) + 3'd3, 8'h00, 10'd1,   1'b0);

      for (i = 0; i < 150; i++) queue_random(35, 30, 15, 18, 2, 1'b0);
      queue_random(90, 6, 0, 4, 0, 1'b1);
      while (gen_len < TEXT_CAP) queue_random(90, 6, 0, 4, 0, 1'b0);
      for (i = 0; i < 40; i++) queue_random(30, 20, 10, 30, 5, 1'b0);
      total_cmds = edit_cmd_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(sent_count == total_cmds && edit_result_q.size() == 0)) @(posedge clock);
      repeat (10) @(posedge clock);
      if (edit_result_q.size() > 0) begin
         $display("%0t: %0d responses never arrived", $time, edit_result_q.size());
         errors++;
      end

      $display("Ran %0d edits: %0d inserts (%0d dropped while full), %0d reads, %0d refused.",
               sent_count, n_insert, n_dropped, n_read, n_refused);
      $display("Line grew to %0d of %0d bytes; %0d responses checked, %0d mismatches.",
               peak_len, TEXT_CAP, rsp_count, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
